[design/slct_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slct_pkg: shared types, constants and lexer step for the config tokenizer
// Holds the queue item layout, the result layout, the lexer modes and the
// single-character lexer step used by the back end.
// ----------------------------------------------------------------------------
package slct_pkg;

  // Token kinds
  localparam logic [3:0] TK_WORD   = 4'd0;
  localparam logic [3:0] TK_SQUOTE = 4'd1;
  localparam logic [3:0] TK_DQUOTE = 4'd2;
  localparam logic [3:0] TK_BOPEN  = 4'd3;
  localparam logic [3:0] TK_BCLOSE = 4'd4;
  localparam logic [3:0] TK_AND    = 4'd5;
  localparam logic [3:0] TK_OR     = 4'd6;
  localparam logic [3:0] TK_SEMI   = 4'd7;
  localparam logic [3:0] TK_NL     = 4'd8;
  localparam logic [3:0] TK_END    = 4'd9;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SQUOTE = 2'd1;
  localparam logic [1:0] ERR_DQUOTE = 2'd2;
  localparam logic [1:0] ERR_SYMBOL = 2'd3;

  // Characters
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQ     = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SQ     = 8'h27;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LV     = 8'h76;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_ESC    = 8'h1B;

  localparam int unsigned MAX_RES = 4;

  typedef enum logic [3:0] {
    M_IDLE,
    M_WORD,
    M_WORDESC,
    M_SQ,
    M_SQESC,
    M_DQ,
    M_DQESC,
    M_DEC,
    M_HEX,
    M_OCT,
    M_AMP,
    M_BAR,
    M_COMMENT
  } mode_t;

  // One joined item as queued between front and back
  typedef struct packed {
    logic       rel_bsl;   // released held backslash goes first
    logic       has_char;
    logic       is_end;
    logic [7:0] ch;
  } q_ent_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       has_byte;
    logic [7:0] tbyte;
    logic       tend;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] esc;
    res_t [3:0] res;
    logic [2:0] cnt;
  } lex_t;

  function automatic res_t mk_res(logic [3:0] kind, logic hb, logic [7:0] b,
                                  logic e, logic [1:0] err);
    res_t r;
    r.kind     = kind;
    r.has_byte = hb;
    r.tbyte    = b;
    r.tend     = e;
    r.err      = err;
    return r;
  endfunction

  // Append a result, drop it once the list is full
  function automatic lex_t lex_put(lex_t s, res_t r);
    lex_t o;
    o = s;
    if (s.cnt < 3'(MAX_RES)) begin
      o.res[s.cnt[1:0]] = r;
      o.cnt = s.cnt + 3'd1;
    end
    return o;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

  function automatic logic is_special(logic [7:0] c);
    return (c == CH_SQ) || (c == CH_DQ) || (c == CH_SEMI) || (c == CH_LBRACE) ||
           (c == CH_RBRACE) || (c == CH_HASH) || (c == CH_BAR) || (c == CH_AMP);
  endfunction

  // Feed one character (or the end mark) to the lexer; a character that
  // closes a token is re-examined in the new mode, at most twice.
  function automatic lex_t lex_step(lex_t s_in, logic is_end, logic [7:0] c);
    lex_t       s;
    logic       go;
    logic       dig;
    logic [7:0] v;
    logic [7:0] hd;
    logic       hex_ok;
    logic [3:0] ak;
    logic [7:0] want;
    s      = s_in;
    go     = 1'b1;
    dig    = !is_end && (c >= CH_0) && (c <= CH_9);
    hex_ok = 1'b0;
    hd     = 8'd0;
    if (dig) begin
      hex_ok = 1'b1;
      hd     = c - CH_0;
    end else if (!is_end && (c >= CH_UA) && (c <= CH_UF)) begin
      hex_ok = 1'b1;
      hd     = c - CH_UA + 8'd10;
    end else if (!is_end && (c >= CH_LA) && (c <= CH_LF)) begin
      hex_ok = 1'b1;
      hd     = c - CH_LA + 8'd10;
    end
    for (int i = 0; i < 3; i++) begin
      if (go) begin
        go = 1'b0;
        case (s.mode)
          M_IDLE: begin
            if (is_end) begin
              s = lex_put(s, mk_res(TK_END, 1'b0, 8'd0, 1'b1, ERR_NONE));
            end else begin
              case (c)
                CH_LBRACE: s = lex_put(s, mk_res(TK_BOPEN, 1'b1, c, 1'b1, ERR_NONE));
                CH_RBRACE: s = lex_put(s, mk_res(TK_BCLOSE, 1'b1, c, 1'b1, ERR_NONE));
                CH_AMP:    s.mode = M_AMP;
                CH_BAR:    s.mode = M_BAR;
                CH_DQ:     s.mode = M_DQ;
                CH_SQ:     s.mode = M_SQ;
                CH_SEMI:   s = lex_put(s, mk_res(TK_SEMI, 1'b0, 8'd0, 1'b1, ERR_NONE));
                CH_NL:     s = lex_put(s, mk_res(TK_NL, 1'b0, 8'd0, 1'b1, ERR_NONE));
                CH_HASH:   s.mode = M_COMMENT;
                CH_SPACE, CH_TAB, CH_CR, CH_VT, CH_FF: ;
                default: begin
                  s.mode = M_WORD;
                  go     = 1'b1;
                end
              endcase
            end
          end
          M_WORD: begin
            if (is_end || is_blank(c) || is_special(c)) begin
              s      = lex_put(s, mk_res(TK_WORD, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
              go     = 1'b1;
            end else begin
              s = lex_put(s, mk_res(TK_WORD, 1'b1, c, 1'b0, ERR_NONE));
              if (c == CH_BSL) s.mode = M_WORDESC;
            end
          end
          M_WORDESC: begin
            if (is_end) begin
              s      = lex_put(s, mk_res(TK_WORD, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
              go     = 1'b1;
            end else begin
              s      = lex_put(s, mk_res(TK_WORD, 1'b1, c, 1'b0, ERR_NONE));
              s.mode = M_WORD;
            end
          end
          M_SQ, M_SQESC: begin
            if (is_end) begin
              s      = lex_put(s, mk_res(TK_SQUOTE, 1'b0, 8'd0, 1'b1, ERR_SQUOTE));
              s      = lex_put(s, mk_res(TK_END, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
            end else if (s.mode == M_SQESC) begin
              s      = lex_put(s, mk_res(TK_SQUOTE, 1'b1, c, 1'b0, ERR_NONE));
              s.mode = M_SQ;
            end else if (c == CH_SQ) begin
              s      = lex_put(s, mk_res(TK_SQUOTE, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
            end else if (c == CH_BSL) begin
              s.mode = M_SQESC;
            end else begin
              s = lex_put(s, mk_res(TK_SQUOTE, 1'b1, c, 1'b0, ERR_NONE));
            end
          end
          M_DQ: begin
            if (is_end) begin
              s      = lex_put(s, mk_res(TK_DQUOTE, 1'b0, 8'd0, 1'b1, ERR_DQUOTE));
              s      = lex_put(s, mk_res(TK_END, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
            end else if (c == CH_DQ) begin
              s      = lex_put(s, mk_res(TK_DQUOTE, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
            end else if (c == CH_BSL) begin
              s.mode = M_DQESC;
            end else begin
              s = lex_put(s, mk_res(TK_DQUOTE, 1'b1, c, 1'b0, ERR_NONE));
            end
          end
          M_DQESC: begin
            if (is_end) begin
              s      = lex_put(s, mk_res(TK_DQUOTE, 1'b0, 8'd0, 1'b1, ERR_DQUOTE));
              s      = lex_put(s, mk_res(TK_END, 1'b0, 8'd0, 1'b1, ERR_NONE));
              s.mode = M_IDLE;
            end else begin
              s.esc = 8'd0;
              if ((c >= CH_1) && (c <= CH_9)) begin
                s.esc  = c - CH_0;
                s.mode = M_DEC;
              end else if (c == CH_LX) begin
                s.mode = M_HEX;
              end else if (c == CH_0) begin
                s.mode = M_OCT;
              end else begin
                case (c)
                  CH_LA:   v = 8'd7;
                  CH_LB:   v = 8'd8;
                  CH_LT:   v = 8'd9;
                  CH_LN:   v = 8'd10;
                  CH_LV:   v = 8'd11;
                  CH_LF:   v = 8'd12;
                  CH_LR:   v = 8'd13;
                  CH_LE:   v = CH_ESC;
                  default: v = c;
                endcase
                s      = lex_put(s, mk_res(TK_DQUOTE, 1'b1, v, 1'b0, ERR_NONE));
                s.mode = M_DQ;
              end
            end
          end
          M_DEC: begin
            if (dig) begin
              s.esc = 8'((s.esc * 8'd10) + hd);
            end else begin
              s      = lex_put(s, mk_res(TK_DQUOTE, 1'b1, s.esc, 1'b0, ERR_NONE));
              s.mode = M_DQ;
              go     = 1'b1;
            end
          end
          M_HEX: begin
            if (hex_ok) begin
              s.esc = {s.esc[3:0], 4'd0} + hd;
            end else begin
              s      = lex_put(s, mk_res(TK_DQUOTE, 1'b1, s.esc, 1'b0, ERR_NONE));
              s.mode = M_DQ;
              go     = 1'b1;
            end
          end
          M_OCT: begin
            if (dig && (c <= CH_7)) begin
              s.esc = {s.esc[4:0], 3'd0} + hd;
            end else begin
              s      = lex_put(s, mk_res(TK_DQUOTE, 1'b1, s.esc, 1'b0, ERR_NONE));
              s.mode = M_DQ;
              go     = 1'b1;
            end
          end
          M_AMP, M_BAR: begin
            ak     = (s.mode == M_AMP) ? TK_AND : TK_OR;
            want   = (s.mode == M_AMP) ? CH_AMP : CH_BAR;
            s.mode = M_IDLE;
            if (!is_end && (c == want)) begin
              s = lex_put(s, mk_res(ak, 1'b0, 8'd0, 1'b1, ERR_NONE));
            end else begin
              s  = lex_put(s, mk_res(ak, 1'b0, 8'd0, 1'b1, ERR_SYMBOL));
              go = is_end;
            end
          end
          M_COMMENT: begin
            if (is_end) begin
              s.mode = M_IDLE;
              go     = 1'b1;
            end else if (c == CH_NL) begin
              s.mode = M_IDLE;
            end
          end
          default: begin
            s.mode = M_IDLE;
            go     = 1'b1;
          end
        endcase
      end
    end
    return s;
  endfunction

endpackage
`default_nettype wire

[design/shell_like_config_tokenizer_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// shell_like_config_tokenizer_core: streaming tokenizer for config text
// Line joiner, item queue and lexer with a registered result stage.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_kind, in_text_byte
//   out_    | output    | out_valid/out_stall| token_kind, has_byte, token_byte,
//           |           |                    | token_end, error_code, run_last
//
// One item per cycle enters while in_stall is low; each gives 0..4 results
// through the single result register and leaves the queue with its last one,
// or at once if it has none; results go from the queue head into that register.
// Reset is synchronous; no clearing pass, the block is ready at once.
// in_stall rises only while the queue is full; out_stall holds the result.
// ----------------------------------------------------------------------------
module shell_like_config_tokenizer_core #(
  parameter int unsigned QDEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_text_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [3:0]      out_token_kind,
  output logic            out_has_byte,
  output logic [7:0]      out_token_byte,
  output logic            out_token_end,
  output logic [1:0]      out_error_code,
  output logic            out_run_last
);

  logic             in_acc;
  logic             q_push;
  slct_pkg::q_ent_t q_in;
  logic             q_full;
  logic             q_hd_valid;
  slct_pkg::q_ent_t q_hd;
  logic             q_pop;
  slct_pkg::res_t   res;

  assign in_stall = q_full;
  assign in_acc   = in_valid && !in_stall;

  slct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .kind      (in_kind),
    .text_byte (in_text_byte),
    .push      (q_push),
    .ent       (q_in)
  );

  slct_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ent (q_in),
    .pop      (q_pop),
    .full     (q_full),
    .hd_valid (q_hd_valid),
    .hd_ent   (q_hd)
  );

  slct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .hd_valid  (q_hd_valid),
    .hd_ent    (q_hd),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res),
    .out_last  (out_run_last)
  );

  assign out_token_kind = res.kind;
  assign out_has_byte   = res.has_byte;
  assign out_token_byte = res.tbyte;
  assign out_token_end  = res.tend;
  assign out_error_code = res.err;

  // nothing is queued once the end mark has gone in
  a_no_push_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_kind) |=> !q_push)
    else $error("item queued after end of input");

  a_open_token_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_token_end) |-> out_has_byte)
    else $error("unfinished token result without a byte");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_error_code != slct_pkg::ERR_NONE)) |->
      (out_token_end && !out_has_byte))
    else $error("error result carries a byte or leaves token open");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_token_kind == slct_pkg::TK_END)) |-> out_run_last)
    else $error("end token not last result of its item");

endmodule
`default_nettype wire

[design/slct_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slct_front: line joiner
// Accepts input items, holds back a trailing backslash and drops a newline
// that follows an odd backslash run; queues the joined characters.
// ----------------------------------------------------------------------------
module slct_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc,
  input  wire logic             kind,
  input  wire logic [7:0]       text_byte,
  output logic                  push,
  output slct_pkg::q_ent_t      ent
);

  logic held_r, held_nxt;
  logic odd_r, odd_nxt;
  logic fin_r, fin_nxt;

  always_comb begin
    held_nxt     = held_r;
    odd_nxt      = odd_r;
    fin_nxt      = fin_r;
    ent.rel_bsl  = 1'b0;
    ent.has_char = 1'b0;
    ent.is_end   = kind;
    ent.ch       = text_byte;
    if (acc && !fin_r) begin
      if (kind) begin
        ent.rel_bsl  = held_r;
        ent.has_char = 1'b1;
        held_nxt     = 1'b0;
        odd_nxt      = 1'b0;
        fin_nxt      = 1'b1;
      end else if (text_byte == slct_pkg::CH_BSL) begin
        // earlier held backslash goes out, this one is held
        ent.rel_bsl = held_r;
        held_nxt    = 1'b1;
        odd_nxt     = !odd_r;
      end else if ((text_byte == slct_pkg::CH_NL) && held_r && odd_r) begin
        // continued line: drop newline and the held backslash
        held_nxt = 1'b0;
        odd_nxt  = 1'b0;
      end else begin
        ent.rel_bsl  = held_r;
        ent.has_char = 1'b1;
        held_nxt     = 1'b0;
        odd_nxt      = 1'b0;
      end
    end
  end

  assign push = ent.rel_bsl || ent.has_char;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
      odd_r  <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      held_r <= held_nxt;
      odd_r  <= odd_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule
`default_nettype wire

[design/slct_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slct_fifo: joined-item queue
// Small first-in first-out queue between the line joiner and the lexer.
// ----------------------------------------------------------------------------
module slct_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire slct_pkg::q_ent_t  push_ent,
  input  wire logic              pop,
  output logic                   full,
  output logic                   hd_valid,
  output slct_pkg::q_ent_t       hd_ent
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  slct_pkg::q_ent_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign hd_valid = (cnt_r != '0);
  assign hd_ent   = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && hd_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    if (do_pop)  rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[design/slct_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slct_back: lexer and result sequencer
// Lexes the queue head, sends its results one per cycle via an output register
// while out_stall is low, and commits lexer state with the last result.
// ----------------------------------------------------------------------------
module slct_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              hd_valid,
  input  wire slct_pkg::q_ent_t  hd_ent,
  output logic                   pop,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output slct_pkg::res_t         out_res,
  output logic                   out_last
);

  slct_pkg::mode_t mode_r, mode_nxt;
  logic [7:0]      esc_r, esc_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            oval_r, oval_nxt;
  slct_pkg::res_t  ores_r, ores_nxt;
  logic            olast_r, olast_nxt;

  slct_pkg::lex_t  lx0, lx1, lx2;
  logic            out_free;
  logic            is_last;
  logic            load;

  always_comb begin
    lx0      = '0;
    lx0.mode = mode_r;
    lx0.esc  = esc_r;
    lx1 = hd_ent.rel_bsl ? slct_pkg::lex_step(lx0, 1'b0, slct_pkg::CH_BSL) : lx0;
    lx2 = hd_ent.has_char ? slct_pkg::lex_step(lx1, hd_ent.is_end, hd_ent.ch) : lx1;
  end

  assign out_free = !oval_r || !out_stall;
  assign is_last  = ({1'b0, idx_r} == (lx2.cnt - 3'd1));
  assign load     = hd_valid && out_free && (lx2.cnt != 3'd0);
  // items without results leave the queue at once
  assign pop      = hd_valid && ((lx2.cnt == 3'd0) || (out_free && is_last));

  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    idx_nxt   = idx_r;
    oval_nxt  = oval_r && out_stall;
    ores_nxt  = ores_r;
    olast_nxt = olast_r;
    if (load) begin
      oval_nxt  = 1'b1;
      ores_nxt  = lx2.res[idx_r];
      olast_nxt = is_last;
      idx_nxt   = is_last ? 2'd0 : idx_r + 2'd1;
    end
    if (pop) begin
      mode_nxt = lx2.mode;
      esc_nxt  = lx2.esc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= slct_pkg::M_IDLE;
      esc_r  <= 8'd0;
      idx_r  <= 2'd0;
      oval_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      idx_r  <= idx_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ores_r  <= ores_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = oval_r;
  assign out_res   = ores_r;
  assign out_last  = olast_r;

endmodule
`default_nettype wire

[verif/slct_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// slct_checker: token stream scoreboard for the config tokenizer
// Watches both channels of the tokenizer, works out the token results that
// each accepted text item must give (line joining plus lexing) and compares
// every accepted result, field by field, with the oldest one outstanding.
// ----------------------------------------------------------------------------
module slct_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [3:0] out_token_kind,
  input  wire logic       out_has_byte,
  input  wire logic [7:0] out_token_byte,
  input  wire logic       out_token_end,
  input  wire logic [1:0] out_error_code,
  input  wire logic       out_run_last,
  output int unsigned     mismatches,
  output int unsigned     awaited
);

  typedef struct packed {
    logic [3:0] kind;
    logic       has_byte;
    logic [7:0] tok_byte;
    logic       tok_end;
    logic [1:0] err;
    logic       run_last;
  } token_beat_t;

  // Lexer and line joiner state
  slct_pkg::mode_t lex_mode;
  logic [7:0]      esc_acc;
  logic            bsl_held;
  logic            bsl_odd;
  logic            stream_done;

  token_beat_t step_out[$];
  token_beat_t token_due[$];
  int unsigned err_tally;
  int unsigned beat_no;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", beat_no, what, got, want);
    err_tally++;
  endtask

  function automatic void emit(input logic [3:0] k, input logic hb, input logic [7:0] b,
                               input logic e, input logic [1:0] code);
    token_beat_t r;
    r.kind     = k;
    r.has_byte = hb;
    r.tok_byte = b;
    r.tok_end  = e;
    r.err      = code;
    r.run_last = 1'b0;
    if (step_out.size() < slct_pkg::MAX_RES) step_out.push_back(r);
  endfunction

  function automatic logic ends_word(input logic [7:0] c);
    case (c)
      slct_pkg::CH_SPACE, slct_pkg::CH_TAB, slct_pkg::CH_NL, slct_pkg::CH_VT,
      slct_pkg::CH_FF, slct_pkg::CH_CR, slct_pkg::CH_SQ, slct_pkg::CH_DQ,
      slct_pkg::CH_SEMI, slct_pkg::CH_LBRACE, slct_pkg::CH_RBRACE,
      slct_pkg::CH_HASH, slct_pkg::CH_BAR, slct_pkg::CH_AMP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // End of input inside a quote: error result, then the end token
  function automatic void quote_fail(input logic [3:0] k, input logic [1:0] code);
    emit(k, 1'b0, 8'd0, 1'b1, code);
    emit(slct_pkg::TK_END, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
    stream_done = 1'b1;
    lex_mode    = slct_pkg::M_IDLE;
  endfunction

  // Feed one joined character; a character that closes a token goes round again
  function automatic void lex_char(input logic at_end, input logic [7:0] c);
    logic       again;
    logic [3:0] op_kind;
    logic [7:0] pair;
    logic [7:0] val;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (lex_mode)
        slct_pkg::M_IDLE: begin
          if (at_end) begin
            emit(slct_pkg::TK_END, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
            stream_done = 1'b1;
          end else begin
            case (c)
              slct_pkg::CH_LBRACE:
                emit(slct_pkg::TK_BOPEN, 1'b1, c, 1'b1, slct_pkg::ERR_NONE);
              slct_pkg::CH_RBRACE:
                emit(slct_pkg::TK_BCLOSE, 1'b1, c, 1'b1, slct_pkg::ERR_NONE);
              slct_pkg::CH_AMP:  lex_mode = slct_pkg::M_AMP;
              slct_pkg::CH_BAR:  lex_mode = slct_pkg::M_BAR;
              slct_pkg::CH_DQ:   lex_mode = slct_pkg::M_DQ;
              slct_pkg::CH_SQ:   lex_mode = slct_pkg::M_SQ;
              slct_pkg::CH_SEMI:
                emit(slct_pkg::TK_SEMI, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
              slct_pkg::CH_NL:
                emit(slct_pkg::TK_NL, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
              slct_pkg::CH_HASH: lex_mode = slct_pkg::M_COMMENT;
              slct_pkg::CH_SPACE, slct_pkg::CH_TAB, slct_pkg::CH_CR,
              slct_pkg::CH_VT, slct_pkg::CH_FF: ;
              default: begin
                lex_mode = slct_pkg::M_WORD;
                again    = 1'b1;
              end
            endcase
          end
        end
        slct_pkg::M_WORD: begin
          if (at_end || ends_word(c)) begin
            emit(slct_pkg::TK_WORD, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_IDLE;
            again    = 1'b1;
          end else begin
            emit(slct_pkg::TK_WORD, 1'b1, c, 1'b0, slct_pkg::ERR_NONE);
            if (c == slct_pkg::CH_BSL) lex_mode = slct_pkg::M_WORDESC;
          end
        end
        slct_pkg::M_WORDESC: begin
          if (at_end) begin
            emit(slct_pkg::TK_WORD, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_IDLE;
            again    = 1'b1;
          end else begin
            emit(slct_pkg::TK_WORD, 1'b1, c, 1'b0, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_WORD;
          end
        end
        slct_pkg::M_SQ: begin
          if (at_end) begin
            quote_fail(slct_pkg::TK_SQUOTE, slct_pkg::ERR_SQUOTE);
          end else if (c == slct_pkg::CH_SQ) begin
            emit(slct_pkg::TK_SQUOTE, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_IDLE;
          end else if (c == slct_pkg::CH_BSL) begin
            lex_mode = slct_pkg::M_SQESC;
          end else begin
            emit(slct_pkg::TK_SQUOTE, 1'b1, c, 1'b0, slct_pkg::ERR_NONE);
          end
        end
        slct_pkg::M_SQESC: begin
          if (at_end) begin
            quote_fail(slct_pkg::TK_SQUOTE, slct_pkg::ERR_SQUOTE);
          end else begin
            emit(slct_pkg::TK_SQUOTE, 1'b1, c, 1'b0, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_SQ;
          end
        end
        slct_pkg::M_DQ: begin
          if (at_end) begin
            quote_fail(slct_pkg::TK_DQUOTE, slct_pkg::ERR_DQUOTE);
          end else if (c == slct_pkg::CH_DQ) begin
            emit(slct_pkg::TK_DQUOTE, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_IDLE;
          end else if (c == slct_pkg::CH_BSL) begin
            lex_mode = slct_pkg::M_DQESC;
          end else begin
            emit(slct_pkg::TK_DQUOTE, 1'b1, c, 1'b0, slct_pkg::ERR_NONE);
          end
        end
        slct_pkg::M_DQESC: begin
          if (at_end) begin
            quote_fail(slct_pkg::TK_DQUOTE, slct_pkg::ERR_DQUOTE);
          end else begin
            esc_acc = 8'd0;
            if (c >= slct_pkg::CH_1 && c <= slct_pkg::CH_9) begin
              esc_acc  = c - slct_pkg::CH_0;
              lex_mode = slct_pkg::M_DEC;
            end else if (c == slct_pkg::CH_LX) begin
              lex_mode = slct_pkg::M_HEX;
            end else if (c == slct_pkg::CH_0) begin
              lex_mode = slct_pkg::M_OCT;
            end else begin
              case (c)
                slct_pkg::CH_LA: val = 8'd7;
                slct_pkg::CH_LB: val = 8'd8;
                slct_pkg::CH_LT: val = 8'd9;
                slct_pkg::CH_LN: val = 8'd10;
                slct_pkg::CH_LV: val = 8'd11;
                slct_pkg::CH_LF: val = 8'd12;
                slct_pkg::CH_LR: val = 8'd13;
                slct_pkg::CH_LE: val = slct_pkg::CH_ESC;
                default:         val = c;
              endcase
              emit(slct_pkg::TK_DQUOTE, 1'b1, val, 1'b0, slct_pkg::ERR_NONE);
              lex_mode = slct_pkg::M_DQ;
            end
          end
        end
        // Numeric escapes wrap modulo 256; the closing byte is seen again
        slct_pkg::M_DEC: begin
          if (!at_end && c >= slct_pkg::CH_0 && c <= slct_pkg::CH_9) begin
            esc_acc = esc_acc * 8'd10 + (c - slct_pkg::CH_0);
          end else begin
            emit(slct_pkg::TK_DQUOTE, 1'b1, esc_acc, 1'b0, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_DQ;
            again    = 1'b1;
          end
        end
        slct_pkg::M_HEX: begin
          if (!at_end && c >= slct_pkg::CH_0 && c <= slct_pkg::CH_9) begin
            esc_acc = esc_acc * 8'd16 + (c - slct_pkg::CH_0);
          end else if (!at_end && c >= slct_pkg::CH_UA && c <= slct_pkg::CH_UF) begin
            esc_acc = esc_acc * 8'd16 + (c - slct_pkg::CH_UA + 8'd10);
          end else if (!at_end && c >= slct_pkg::CH_LA && c <= slct_pkg::CH_LF) begin
            esc_acc = esc_acc * 8'd16 + (c - slct_pkg::CH_LA + 8'd10);
          end else begin
            emit(slct_pkg::TK_DQUOTE, 1'b1, esc_acc, 1'b0, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_DQ;
            again    = 1'b1;
          end
        end
        slct_pkg::M_OCT: begin
          if (!at_end && c >= slct_pkg::CH_0 && c <= slct_pkg::CH_7) begin
            esc_acc = esc_acc * 8'd8 + (c - slct_pkg::CH_0);
          end else begin
            emit(slct_pkg::TK_DQUOTE, 1'b1, esc_acc, 1'b0, slct_pkg::ERR_NONE);
            lex_mode = slct_pkg::M_DQ;
            again    = 1'b1;
          end
        end
        slct_pkg::M_AMP, slct_pkg::M_BAR: begin
          op_kind  = (lex_mode == slct_pkg::M_AMP) ? slct_pkg::TK_AND : slct_pkg::TK_OR;
          pair     = (lex_mode == slct_pkg::M_AMP) ? slct_pkg::CH_AMP : slct_pkg::CH_BAR;
          lex_mode = slct_pkg::M_IDLE;
          if (!at_end && c == pair) begin
            emit(op_kind, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_NONE);
          end else begin
            // lone symbol swallows the next character, unless it is the end
            emit(op_kind, 1'b0, 8'd0, 1'b1, slct_pkg::ERR_SYMBOL);
            again = at_end;
          end
        end
        slct_pkg::M_COMMENT: begin
          if (at_end) begin
            lex_mode = slct_pkg::M_IDLE;
            again    = 1'b1;
          end else if (c == slct_pkg::CH_NL) begin
            lex_mode = slct_pkg::M_IDLE;
          end
        end
        default: begin
          lex_mode = slct_pkg::M_IDLE;
          again    = 1'b1;
        end
      endcase
    end
  endfunction

  function automatic void flush_held_backslash();
    if (bsl_held) lex_char(1'b0, slct_pkg::CH_BSL);
    bsl_held = 1'b0;
    bsl_odd  = 1'b0;
  endfunction

  // in_kind high marks the end of input
  function automatic void predict_item(input logic at_end, input logic [7:0] b);
    token_beat_t r;
    step_out.delete();
    if (stream_done) return;
    if (at_end) begin
      flush_held_backslash();
      lex_char(1'b1, 8'd0);
    end else if (b == slct_pkg::CH_BSL) begin
      if (bsl_held) lex_char(1'b0, slct_pkg::CH_BSL);
      bsl_held = 1'b1;
      bsl_odd  = !bsl_odd;
    end else if (b == slct_pkg::CH_NL && bsl_held && bsl_odd) begin
      // line continuation: drop the newline and the last backslash
      bsl_held = 1'b0;
      bsl_odd  = 1'b0;
    end else begin
      flush_held_backslash();
      lex_char(1'b0, b);
    end
    foreach (step_out[i]) begin
      r          = step_out[i];
      r.run_last = (i == step_out.size() - 1);
      token_due.push_back(r);
    end
  endfunction

  task automatic check_result();
    token_beat_t want;
    if (token_due.size() == 0) begin
      report_mismatch("result with nothing outstanding, token_kind", out_token_kind, -1);
    end else begin
      want = token_due.pop_front();
      if (out_token_kind !== want.kind)
        report_mismatch("token_kind", out_token_kind, want.kind);
      if (out_has_byte !== want.has_byte)
        report_mismatch("has_byte", out_has_byte, want.has_byte);
      if (out_token_byte !== want.tok_byte)
        report_mismatch("token_byte", out_token_byte, want.tok_byte);
      if (out_token_end !== want.tok_end)
        report_mismatch("token_end", out_token_end, want.tok_end);
      if (out_error_code !== want.err)
        report_mismatch("error_code", out_error_code, want.err);
      if (out_run_last !== want.run_last)
        report_mismatch("run_last", out_run_last, want.run_last);
    end
    beat_no++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode    = slct_pkg::M_IDLE;
      esc_acc     = 8'd0;
      bsl_held    = 1'b0;
      bsl_odd     = 1'b0;
      stream_done = 1'b0;
      err_tally   = 0;
      beat_no     = 0;
      token_due.delete();
    end else begin
      if (in_valid && !in_stall) predict_item(in_kind, in_text_byte);
      if (out_valid && !out_stall) check_result();
    end
    awaited    <= token_due.size();
    mismatches <= err_tally;
  end

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the config tokenizer
// Drives a short directed text, then randomly built words, quoted strings,
// escapes, operators, comments and continued lines, and closes the stream
// with one end-of-input case. Both channels idle at random; the scoreboard
// beside the block checks every token result.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic        KIND_TEXT     = 1'b0;
  localparam logic        KIND_EOI      = 1'b1;
  localparam int unsigned ITEM_TARGET   = 380;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 20;

  typedef enum int unsigned {
    PIECE_WORD, PIECE_WORD_ESC, PIECE_SQUOTE, PIECE_DQUOTE, PIECE_OPERATOR,
    PIECE_BLANKS, PIECE_COMMENT, PIECE_BSL_RUN, PIECE_LONE_SYMBOL, PIECE_NOISE
  } piece_t;

  typedef enum int unsigned {
    DQ_PLAIN, DQ_LETTER, DQ_ANY, DQ_DEC, DQ_HEX, DQ_OCT
  } dq_part_t;

  typedef enum int unsigned {
    END_IDLE, END_IN_WORD, END_IN_SQUOTE, END_IN_DQUOTE, END_IN_ESCAPE,
    END_AFTER_SYMBOL, END_IN_COMMENT, END_HELD_BSL
  } ending_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_kind      = KIND_TEXT;
  logic [7:0]  in_text_byte = 8'd0;
  logic        out_stall    = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  out_token_kind;
  logic        out_has_byte;
  logic [7:0]  out_token_byte;
  logic        out_token_end;
  logic [1:0]  out_error_code;
  logic        out_run_last;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned stall_left  = 0;
  int unsigned rx_wait;
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;

  shell_like_config_tokenizer_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_has_byte   (out_has_byte),
    .out_token_byte (out_token_byte),
    .out_token_end  (out_token_end),
    .out_error_code (out_error_code),
    .out_run_last   (out_run_last)
  );

  slct_checker token_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_token_kind (out_token_kind),
    .out_has_byte   (out_has_byte),
    .out_token_byte (out_token_byte),
    .out_token_end  (out_token_end),
    .out_error_code (out_error_code),
    .out_run_last   (out_run_last),
    .mismatches     (mismatches),
    .awaited        (awaited)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: hold off for a random number of cycles after each result
  always @(posedge clk) begin
    if (out_stall) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && out_valid) begin
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 15);
      if (rx_wait != 0) begin
        out_stall  <= 1'b1;
        stall_left <= rx_wait;
      end
      if ($urandom_range(0, 39) == 0) rx_quiet <= !rx_quiet;
    end
  end

  task automatic send_item(input logic k, input logic [7:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid     <= 1'b0;
      in_text_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= k;
    in_text_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if ($urandom_range(0, 39) == 0) tx_quiet = !tx_quiet;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(KIND_TEXT, s[i]);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_from(input string set);
    return set[$urandom_range(0, set.len() - 1)];
  endfunction

  function automatic logic [7:0] word_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(128, 255));
    return pick_from("abcxyzABCXYZ0189_-./=:@$%*!?,+~");
  endfunction

  // Any byte that neither closes the quote nor starts an escape
  function automatic logic [7:0] quoted_byte(input logic [7:0] closer);
    logic [7:0] c;
    do c = 8'($urandom); while (c == closer || c == slct_pkg::CH_BSL);
    return c;
  endfunction

  task automatic send_dquote();
    int unsigned n;
    send_item(KIND_TEXT, slct_pkg::CH_DQ);
    repeat ($urandom_range(0, 5)) begin
      case (dq_part_t'($urandom_range(0, DQ_OCT)))
        DQ_PLAIN:  send_item(KIND_TEXT, quoted_byte(slct_pkg::CH_DQ));
        DQ_LETTER: begin
          send_item(KIND_TEXT, slct_pkg::CH_BSL);
          send_item(KIND_TEXT, pick_from("abtnvfre"));
        end
        DQ_ANY: begin
          send_item(KIND_TEXT, slct_pkg::CH_BSL);
          send_item(KIND_TEXT, 8'($urandom));
        end
        DQ_DEC: begin
          send_item(KIND_TEXT, slct_pkg::CH_BSL);
          send_item(KIND_TEXT, pick_from("123456789"));
          repeat ($urandom_range(0, 3)) send_item(KIND_TEXT, pick_from("0123456789"));
        end
        DQ_HEX: begin
          send_item(KIND_TEXT, slct_pkg::CH_BSL);
          send_item(KIND_TEXT, slct_pkg::CH_LX);
          n = $urandom_range(0, 3);
          repeat (n) send_item(KIND_TEXT, pick_from("0123456789abcdefABCDEF"));
        end
        default: begin
          send_item(KIND_TEXT, slct_pkg::CH_BSL);
          send_item(KIND_TEXT, slct_pkg::CH_0);
          repeat ($urandom_range(0, 4)) send_item(KIND_TEXT, pick_from("01234567"));
        end
      endcase
    end
    send_item(KIND_TEXT, slct_pkg::CH_DQ);
  endtask

  task automatic send_piece();
    case (piece_t'($urandom_range(0, PIECE_NOISE)))
      PIECE_WORD: begin
        repeat ($urandom_range(1, 6)) send_item(KIND_TEXT, word_byte());
      end
      PIECE_WORD_ESC: begin
        send_item(KIND_TEXT, word_byte());
        send_item(KIND_TEXT, slct_pkg::CH_BSL);
        send_item(KIND_TEXT, 8'($urandom));
        if ($urandom_range(0, 1) == 0) send_item(KIND_TEXT, word_byte());
      end
      PIECE_SQUOTE: begin
        send_item(KIND_TEXT, slct_pkg::CH_SQ);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_item(KIND_TEXT, slct_pkg::CH_BSL);
            send_item(KIND_TEXT, 8'($urandom));
          end else begin
            send_item(KIND_TEXT, quoted_byte(slct_pkg::CH_SQ));
          end
        end
        send_item(KIND_TEXT, slct_pkg::CH_SQ);
      end
      PIECE_DQUOTE: send_dquote();
      PIECE_OPERATOR: begin
        case ($urandom_range(0, 5))
          0:       send_text("&&");
          1:       send_text("||");
          2:       send_item(KIND_TEXT, slct_pkg::CH_SEMI);
          3:       send_item(KIND_TEXT, slct_pkg::CH_LBRACE);
          4:       send_item(KIND_TEXT, slct_pkg::CH_RBRACE);
          default: send_item(KIND_TEXT, slct_pkg::CH_NL);
        endcase
      end
      PIECE_BLANKS: begin
        repeat ($urandom_range(1, 3)) send_item(KIND_TEXT, pick_from(" \t\r\v\f"));
      end
      PIECE_COMMENT: begin
        send_item(KIND_TEXT, slct_pkg::CH_HASH);
        repeat ($urandom_range(0, 5)) send_item(KIND_TEXT, quoted_byte(slct_pkg::CH_NL));
        send_item(KIND_TEXT, slct_pkg::CH_NL);
      end
      PIECE_BSL_RUN: begin
        // odd runs join the line, even runs leave the newline standing
        repeat ($urandom_range(1, 4)) send_item(KIND_TEXT, slct_pkg::CH_BSL);
        send_item(KIND_TEXT, slct_pkg::CH_NL);
        if ($urandom_range(0, 1) == 0) send_item(KIND_TEXT, word_byte());
      end
      PIECE_LONE_SYMBOL: begin
        send_item(KIND_TEXT,
                  ($urandom_range(0, 1) == 0) ? slct_pkg::CH_AMP : slct_pkg::CH_BAR);
        send_item(KIND_TEXT, 8'($urandom));
      end
      default: send_item(KIND_TEXT, 8'($urandom));
    endcase
  endtask

  // Close the stream once; everything after the end token must stay silent
  task automatic send_ending();
    case (ending_t'($urandom_range(0, END_HELD_BSL)))
      END_IDLE:         send_text(" ");
      END_IN_WORD:      send_text("ab");
      END_IN_SQUOTE:    send_text("'ab");
      END_IN_DQUOTE:    send_text("\"ab");
      END_IN_ESCAPE:    send_text("\"\\x4");
      END_AFTER_SYMBOL:
        send_item(KIND_TEXT,
                  ($urandom_range(0, 1) == 0) ? slct_pkg::CH_AMP : slct_pkg::CH_BAR);
      END_IN_COMMENT:   send_text("#ab");
      default:          send_text("ab\\");
    endcase
    send_item(KIND_EOI, 8'($urandom));
    repeat (4) send_item(1'($urandom), 8'($urandom));
  endtask

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // braces, separators, both pairs, a lone symbol, a continued word
    send_text("{};&&||&xa\\\n");
    send_item(KIND_TEXT, 8'h00);
    send_item(KIND_TEXT, 8'hFF);
    // escape letter, short hex escape ended by a quote, comment eating its newline
    send_text("\t\"\\e\\x4'\"#\n");

    while (items_sent < ITEM_TARGET) begin
      send_piece();
      if (!paused && items_sent >= ITEM_TARGET / 2) begin
        in_valid <= 1'b0;
        wait_drained();
        paused = 1'b1;
      end
    end

    send_ending();
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
